FILE: hdl/sspws_pkg.sv
package sspws_pkg;

  localparam int MAX_WINDOW_LEN = 4096;
  localparam int SAMPLE_BITS    = 16;
  localparam int LEN_W          = $clog2(MAX_WINDOW_LEN + 1);
  localparam int IDX_W          = 16;
  localparam int THR_W          = 16;
  localparam int GAP_W          = 8;
  localparam int SUM_W          = 43;
  localparam int SQ_W           = 2 * SAMPLE_BITS;
  localparam int CMP_W          = (LEN_W > GAP_W) ? LEN_W : GAP_W;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW_LEN);
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_THRESHOLD = 1'd0,
    REG_MIN_BAND_GAP   = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    POL_EMPTY = 2'd0,
    POL_POS   = 2'd1,
    POL_NEG   = 2'd2
  } polarity_t;

  typedef struct packed {
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [IDX_W-1:0]              sample_index;
  } sample_t;

  typedef struct packed {
    logic                   accepted;
    logic [LEN_W-1:0]       window_length;
    logic [1:0]             polarity;
    logic [SAMPLE_BITS-1:0] abs_peak;
    logic [SUM_W-1:0]       square_sum;
    logic [LEN_W-1:0]       bandwidth;
    logic [LEN_W-1:0]       band_count;
    logic [IDX_W-1:0]       start_index;
    logic [IDX_W-1:0]       end_index;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]       length_count;
    polarity_t              sign_state;
    logic [SAMPLE_BITS-1:0] peak_abs;
    logic [SUM_W-1:0]       energy_sum;
    logic [LEN_W-1:0]       current_run;
    logic [LEN_W-1:0]       longest_run;
    logic [LEN_W-1:0]       bands_seen;
    logic [LEN_W-1:0]       last_exit_pos;
    logic                   inside_band;
    logic [IDX_W-1:0]       first_index;
    logic [IDX_W-1:0]       latest_index;
  } win_state_t;

  typedef struct packed {
    logic [THR_W-1:0] band_threshold;
    logic [GAP_W-1:0] min_band_gap;
  } cfg_t;

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v < LEN_MAX) ? v + LEN_W'(1) : LEN_MAX;
  endfunction

endpackage

FILE: hdl/sspws_update.sv
module sspws_update (
  input  sspws_pkg::sample_t    item,
  input  sspws_pkg::win_state_t st,
  input  sspws_pkg::cfg_t       cfg,
  output sspws_pkg::win_state_t nxt,
  output sspws_pkg::result_t    res
);

  logic                                neg;
  logic [sspws_pkg::SAMPLE_BITS-1:0]   raw;
  logic [sspws_pkg::SAMPLE_BITS-1:0]   mag;
  logic [sspws_pkg::SQ_W-1:0]          sq;
  logic [sspws_pkg::SUM_W:0]           sum_wide;
  logic                                join_ok;
  logic                                acc;
  logic [sspws_pkg::LEN_W-1:0]         len_new;
  logic [sspws_pkg::LEN_W-1:0]         run_new;
  logic [sspws_pkg::LEN_W-1:0]         gap_diff;
  logic                                gap_ok;

  assign raw      = item.sample_value;
  assign neg      = raw[sspws_pkg::SAMPLE_BITS-1];
  assign mag      = neg ? (~raw + 1'b1) : raw;
  assign sq       = mag * mag;
  assign sum_wide = {1'b0, st.energy_sum} + (sspws_pkg::SUM_W + 1)'(sq);
  assign len_new  = sspws_pkg::sat_inc(st.length_count);
  assign run_new  = sspws_pkg::sat_inc(st.current_run);
  assign gap_diff = len_new - st.last_exit_pos;
  assign gap_ok   = (st.last_exit_pos == '0) ||
                    ((len_new >= st.last_exit_pos) &&
                     (sspws_pkg::CMP_W'(gap_diff) > sspws_pkg::CMP_W'(cfg.min_band_gap)));

  always_comb begin
    nxt     = st;
    acc     = 1'b0;
    join_ok = 1'b0;
    if (item.mode) begin
      nxt.length_count  = '0;
      nxt.sign_state    = sspws_pkg::POL_EMPTY;
      nxt.peak_abs      = '0;
      nxt.energy_sum    = '0;
      nxt.current_run   = '0;
      nxt.longest_run   = '0;
      nxt.bands_seen    = '0;
      nxt.last_exit_pos = '0;
      nxt.inside_band   = 1'b0;
    end else begin
      if (st.length_count == '0) begin
        nxt.sign_state  = neg ? sspws_pkg::POL_NEG : sspws_pkg::POL_POS;
        nxt.first_index = item.sample_index;
        nxt.peak_abs    = '0;
        join_ok         = 1'b1;
      end else begin
        unique case (st.sign_state)
          sspws_pkg::POL_POS: join_ok = !neg;
          sspws_pkg::POL_NEG: join_ok = neg;
          default:            join_ok = 1'b0;
        endcase
      end
      if (join_ok) begin
        acc              = 1'b1;
        nxt.latest_index = item.sample_index;
        nxt.length_count = len_new;
        if (mag > nxt.peak_abs) begin
          nxt.peak_abs = mag;
        end
        if (cfg.band_threshold != '0) begin
          if (mag >= cfg.band_threshold) begin
            nxt.current_run = run_new;
            if (run_new > st.longest_run) begin
              nxt.longest_run = run_new;
            end
            if (!st.inside_band && gap_ok) begin
              nxt.bands_seen = sspws_pkg::sat_inc(st.bands_seen);
            end
            nxt.inside_band = 1'b1;
          end else begin
            nxt.current_run = '0;
            if (st.inside_band) begin
              nxt.last_exit_pos = len_new;
            end
            nxt.inside_band = 1'b0;
          end
        end
        if (sum_wide > {1'b0, sspws_pkg::SUM_MAX}) begin
          nxt.energy_sum = sspws_pkg::SUM_MAX;
        end else begin
          nxt.energy_sum = sum_wide[sspws_pkg::SUM_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res.accepted      = acc;
    res.window_length = nxt.length_count;
    res.polarity      = nxt.sign_state;
    res.abs_peak      = nxt.peak_abs;
    res.square_sum    = nxt.energy_sum;
    res.bandwidth     = (cfg.band_threshold != '0) ? nxt.longest_run : nxt.length_count;
    res.band_count    = nxt.bands_seen;
    res.start_index   = nxt.first_index;
    res.end_index     = nxt.latest_index;
  end

endmodule

FILE: hdl/same_sign_peak_window_stats.sv
// channel   direction  handshake                    payload
// sample    in         sample_valid / sample_stall  sample (sspws_pkg::sample_t)
// result    out        result_valid / result_stall  result (sspws_pkg::result_t)
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// one item per cycle sustained while the result side is not stalled
// window statistics are computed combinationally from the input register by the
// state update path (abs, one 16x16 square, saturating 43-bit add, counters)
// reset clears window state and both valid flags, and resets the config registers
// a stalled result holds the input register; sample_stall rises only when it is full
module same_sign_peak_window_stats (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  sspws_pkg::sample_t                 sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output sspws_pkg::result_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sspws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sspws_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                  stage_valid;
  sspws_pkg::sample_t    stage_item;
  sspws_pkg::win_state_t win;
  sspws_pkg::win_state_t win_next;
  sspws_pkg::result_t    res_next;
  sspws_pkg::cfg_t       cfg;
  logic                  advance;

  assign cfg_ready    = 1'b1;
  assign advance      = !result_valid || !result_stall;
  assign sample_stall = stage_valid && !advance;

  sspws_update u_update (
    .item (stage_item),
    .st   (win),
    .cfg  (cfg),
    .nxt  (win_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_threshold <= '0;
      cfg.min_band_gap   <= sspws_pkg::GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sspws_pkg::cfg_reg_t'(cfg_index))
        sspws_pkg::REG_BAND_THRESHOLD: cfg.band_threshold <= cfg_data[sspws_pkg::THR_W-1:0];
        sspws_pkg::REG_MIN_BAND_GAP:   cfg.min_band_gap   <= cfg_data[sspws_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      win          <= '0;
    end else begin
      if (!sample_stall) begin
        stage_valid <= sample_valid;
      end
      if (advance) begin
        result_valid <= stage_valid;
        if (stage_valid) begin
          win <= win_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall) begin
      stage_item <= sample;
    end
    if (advance && stage_valid) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_has_polarity : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.accepted |-> result.polarity != sspws_pkg::POL_EMPTY)
    else $error("accepted item with empty polarity");

  a_empty_matches_length : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.window_length == '0) ==
                      (result.polarity == sspws_pkg::POL_EMPTY)))
    else $error("window length and polarity disagree");

  a_length_bound : assert property (@(posedge clk) disable iff (rst)
    win.length_count <= sspws_pkg::LEN_MAX && win.longest_run <= win.length_count)
    else $error("window length or run out of bounds");

  a_stall_only_full : assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> stage_valid && result_valid && result_stall)
    else $error("sample stalled without a full pipeline");
`endif

endmodule

FILE: test/window_stats_checker.sv
`timescale 1ns / 100ps

module window_stats_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  input  logic                             sample_stall,
  input  sspws_pkg::sample_t               sample,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  sspws_pkg::result_t               result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sspws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sspws_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending
);

  import sspws_pkg::*;

  localparam int SHOWN_MISMATCHES = 40;

  logic [THR_W-1:0]       thr_reg;
  logic [GAP_W-1:0]       gap_reg;

  logic [LEN_W-1:0]       win_len;
  polarity_t              win_pol;
  logic [SAMPLE_BITS-1:0] peak_mag;
  logic [SUM_W-1:0]       energy;
  logic [LEN_W-1:0]       run_len;
  logic [LEN_W-1:0]       run_best;
  logic [LEN_W-1:0]       band_total;
  logic [LEN_W-1:0]       exit_pos;
  logic                   in_band;
  logic [IDX_W-1:0]       first_idx;
  logic [IDX_W-1:0]       last_idx;

  result_t due_results[$];
  int      fails = 0;

  function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] v);
    return (v < LEN_MAX) ? v + 1'b1 : LEN_MAX;
  endfunction

  task automatic empty_stats();
    win_len    = '0;
    win_pol    = POL_EMPTY;
    peak_mag   = '0;
    energy     = '0;
    run_len    = '0;
    run_best   = '0;
    band_total = '0;
    exit_pos   = '0;
    in_band    = 1'b0;
  endtask

  task automatic advance_window(input sample_t s, output result_t r);
    logic                   neg;
    logic [SAMPLE_BITS:0]   mag;
    logic [SQ_W+1:0]        sq;
    logic [SUM_W:0]         total;
    logic                   joins;
    neg   = s.sample_value[SAMPLE_BITS-1];
    mag   = neg ? (((SAMPLE_BITS+1)'(1) << SAMPLE_BITS) - {1'b0, s.sample_value})
                : {1'b0, s.sample_value};
    sq    = mag * mag;
    joins = 1'b0;
    if (s.mode) begin
      empty_stats();
    end else begin
      if (win_len == '0) begin
        win_pol   = neg ? POL_NEG : POL_POS;
        first_idx = s.sample_index;
        peak_mag  = '0;
        joins     = 1'b1;
      end else if (win_pol == POL_POS) begin
        joins = !neg;
      end else if (win_pol == POL_NEG) begin
        joins = neg;
      end
      if (joins) begin
        last_idx = s.sample_index;
        win_len  = bump(win_len);
        if (mag > peak_mag) peak_mag = mag[SAMPLE_BITS-1:0];
        if (thr_reg != '0) begin
          if (mag >= thr_reg) begin
            run_len = bump(run_len);
            if (run_len > run_best) run_best = run_len;
            // re-entry only counts after enough samples outside the band
            if (!in_band && (exit_pos == '0 ||
                (win_len >= exit_pos && win_len - exit_pos > gap_reg)))
              band_total = bump(band_total);
            in_band = 1'b1;
          end else begin
            run_len = '0;
            if (in_band) exit_pos = win_len;
            in_band = 1'b0;
          end
        end
        total = energy + sq;
        if (total > {1'b0, SUM_MAX}) energy = SUM_MAX;
        else energy = total[SUM_W-1:0];
      end
    end
    r.accepted      = joins;
    r.window_length = win_len;
    r.polarity      = win_pol;
    r.abs_peak      = peak_mag;
    r.square_sum    = energy;
    r.bandwidth     = (thr_reg != '0) ? run_best : win_len;
    r.band_count    = band_total;
    r.start_index   = first_idx;
    r.end_index     = last_idx;
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= SHOWN_MISMATCHES)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      thr_reg   = '0;
      gap_reg   = GAP_RESET;
      empty_stats();
      first_idx = '0;
      last_idx  = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BAND_THRESHOLD: thr_reg = cfg_data[THR_W-1:0];
          REG_MIN_BAND_GAP:   gap_reg = cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        advance_window(sample, want);
        due_results = {due_results, want};
      end
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= SHOWN_MISMATCHES)
            $display("%0t ns: result with nothing expected, expected none, got length %0d",
                     $time, result.window_length);
        end else begin
          want = due_results.pop_front();
          check_field("accepted", want.accepted, result.accepted);
          check_field("window_length", want.window_length, result.window_length);
          check_field("polarity", want.polarity, result.polarity);
          check_field("abs_peak", want.abs_peak, result.abs_peak);
          check_field("square_sum", want.square_sum, result.square_sum);
          check_field("bandwidth", want.bandwidth, result.bandwidth);
          check_field("band_count", want.band_count, result.band_count);
          check_field("start_index", want.start_index, result.start_index);
          check_field("end_index", want.end_index, result.end_index);
        end
      end
    end
    fail_count <= fails;
    pending    <= due_results.size();
  end

endmodule

FILE: test/same_sign_peak_window_stats_test.sv
`timescale 1ns / 100ps

module same_sign_peak_window_stats_test;

  import sspws_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 10;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  sample_t               sample;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    fails;
  int                    pending;
  int                    idle_cycles = 0;
  int                    items_sent;
  int                    settings_used;
  logic                  hold_req;
  logic                  hold_taken;

  logic [THR_W-1:0]      cur_thr;
  logic                  win_open;
  logic                  win_neg;
  logic [IDX_W-1:0]      next_idx;

  same_sign_peak_window_stats i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  window_stats_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fails),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, free stretches, and one long hold-off on request
  initial begin
    result_stall = 1'b0;
    hold_taken   = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken   = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            result_stall <= 1'b0;
            repeat ($urandom_range(20, 100)) @(posedge clk);
          end
          2, 3, 4: begin
            result_stall <= 1'b1;
            repeat (pick_gap() + 1) @(posedge clk);
          end
          default: begin
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
        endcase
      end
    end
  end

  task automatic send_fields(input logic mode, input logic [SAMPLE_BITS-1:0] value,
                             input logic [IDX_W-1:0] index);
    sample_t s;
    int      gap;
    s.mode         = mode;
    s.sample_value = value;
    s.sample_index = index;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_config(input logic [THR_W-1:0] thr, input logic [GAP_W-1:0] gap);
    wait_drained();
    cfg_index <= REG_BAND_THRESHOLD;
    cfg_data  <= thr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    // upper data bits are don't-care for the gap register
    cfg_index <= REG_MIN_BAND_GAP;
    cfg_data  <= {8'($urandom), gap};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_thr = thr;
    settings_used++;
  endtask

  function automatic int pick_level();
    int t;
    t = cur_thr;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = t + int'($urandom_range(0, 6)) - 3;
      4, 5:       t = $urandom_range(0, 32768);
      6:          t = $urandom_range(0, 15);
      7:          t = (t > 0) ? $urandom_range(0, t - 1) : 0;
      8:          t = $urandom_range(t, 32768);
      default: begin
        case ($urandom_range(0, 3))
          0:       t = 0;
          1:       t = 1;
          2:       t = 32767;
          default: t = 32768;
        endcase
      end
    endcase
    if (t < 0) t = 0;
    if (t > 32768) t = 32768;
    return t;
  endfunction

  task automatic random_item(input int clear_pct);
    logic [IDX_W-1:0] index;
    logic             neg;
    int               mag;
    index    = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : next_idx;
    next_idx = index + 1'b1;
    if ($urandom_range(0, 99) < clear_pct) begin
      win_open = 1'b0;
      send_fields(1'b1, SAMPLE_BITS'($urandom), index);
    end else begin
      if (!win_open) begin
        win_open = 1'b1;
        win_neg  = $urandom_range(0, 1);
        neg      = win_neg;
      end else begin
        // mostly matching sign, some wrong-sign samples to be rejected
        neg = ($urandom_range(0, 99) < 10) ? !win_neg : win_neg;
      end
      mag = pick_level();
      if (neg) send_fields(1'b0, SAMPLE_BITS'(-((mag == 0) ? 1 : mag)), index);
      else send_fields(1'b0, SAMPLE_BITS'((mag > 32767) ? 32767 : mag), index);
    end
  endtask

  task automatic run_phase(input int count, input int clear_pct, input int hold_at,
                           input int drain_at);
    win_open = 1'b0;
    send_fields(1'b1, SAMPLE_BITS'($urandom), next_idx);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_req <= 1'b1;
      if (k == drain_at) wait_drained();
      random_item(clear_pct);
    end
  endtask

  initial begin
    rst           = 1'b1;
    sample_valid  = 1'b0;
    sample        = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_req      = 1'b0;
    cur_thr       = '0;
    win_open      = 1'b0;
    win_neg       = 1'b0;
    next_idx      = '0;
    items_sent    = 0;
    settings_used = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: band tracking off
    send_fields(1'b1, 16'h7fff, 16'hffff);
    send_fields(1'b0, 16'h0000, 16'h0000);
    send_fields(1'b0, 16'h7fff, 16'hffff);
    send_fields(1'b0, 16'hffff, 16'h0001);
    send_fields(1'b0, 16'h8000, 16'h0002);
    send_fields(1'b0, 16'h0000, 16'h0005);
    send_fields(1'b1, 16'h8000, 16'h0000);
    send_fields(1'b0, 16'h8000, 16'h0064);
    send_fields(1'b0, 16'hffff, 16'h0065);
    send_fields(1'b0, 16'h0000, 16'h0066);
    send_fields(1'b0, 16'h0001, 16'h0067);

    // top threshold, widest gap: re-entry inside the gap is not a new band
    write_config(16'd32768, 8'd255);
    send_fields(1'b0, 16'h8000, 16'h0068);
    send_fields(1'b0, 16'h8001, 16'h0069);
    send_fields(1'b0, 16'h8000, 16'h006a);
    send_fields(1'b1, 16'h1234, 16'h006b);
    send_fields(1'b0, 16'h7fff, 16'h006c);

    write_config(16'd3, 8'd0);
    send_fields(1'b1, 16'h0000, 16'h0100);
    send_fields(1'b0, 16'h0003, 16'h0101);
    send_fields(1'b0, 16'h0002, 16'h0102);
    send_fields(1'b0, 16'h0004, 16'h0103);
    send_fields(1'b0, 16'h0005, 16'h0104);
    send_fields(1'b0, 16'h0000, 16'h0105);
    send_fields(1'b0, 16'hfffd, 16'h0106);

    write_config(16'd2, 8'd1);
    send_fields(1'b1, 16'h0000, 16'h0200);
    send_fields(1'b0, 16'h0002, 16'h0201);
    send_fields(1'b0, 16'h0001, 16'h0202);
    send_fields(1'b0, 16'h0002, 16'h0203);

    write_config(16'd0, 8'd2);
    run_phase(150, 5, -1, -1);
    write_config(16'd32768, 8'd255);
    run_phase(200, 1, -1, -1);
    write_config(16'd1, 8'd0);
    run_phase(200, 5, -1, 120);
    write_config(16'd500, 8'd3);
    run_phase(250, 3, 60, -1);
    repeat (4) begin
      write_config(16'($urandom_range(0, 32768)), 8'($urandom_range(0, 255)));
      run_phase(100, $urandom_range(1, 8), -1, -1);
    end
    write_config(16'($urandom_range(1, 64)), 8'($urandom_range(0, 5)));
    run_phase(100, 4, -1, -1);

    // one long negative window near full scale, a few wrong-sign samples
    write_config(16'd1, 8'd0);
    send_fields(1'b1, 16'h0000, next_idx);
    for (int k = 0; k < 150; k++) begin
      if ($urandom_range(0, 49) == 0)
        send_fields(1'b0, SAMPLE_BITS'($urandom_range(0, 32767)), next_idx);
      else
        send_fields(1'b0, SAMPLE_BITS'(-int'($urandom_range(30000, 32768))), next_idx);
      next_idx++;
    end

    // alternating in and out of band with no gap
    write_config(16'd16, 8'd0);
    send_fields(1'b1, 16'h0000, next_idx);
    for (int k = 0; k < 100; k++) begin
      if (k % 2 == 1) send_fields(1'b0, SAMPLE_BITS'($urandom_range(0, 15)), next_idx);
      else send_fields(1'b0, SAMPLE_BITS'($urandom_range(16, 32767)), next_idx);
      next_idx++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d sample items over %0d register settings", items_sent,
             settings_used);
    $display("including long windows, band re-entries and a long result hold-off");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sspws_pkg.sv
hdl/sspws_update.sv
hdl/same_sign_peak_window_stats.sv
test/window_stats_checker.sv
test/same_sign_peak_window_stats_test.sv
